FILE: hw/rtl/rbd_pkg.sv
// Constants, substitution tables and lookup helpers for the ROM byte descrambler.
package rbd_pkg;

    localparam int ADDR_W = 15;
    localparam int DATA_W = 8;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_DIRECTION = 2'd0;

    localparam logic DIR_UNPACK = 1'b0;
    localparam logic DIR_PACK   = 1'b1;

    localparam logic [7:0] KEEP_MASK  = 8'ha5;
    localparam logic [7:0] SUBST_MASK = 8'h5a;

    localparam logic [2:0] SEL_R0 = 3'd0;
    localparam logic [2:0] SEL_R1 = 3'd1;
    localparam logic [2:0] SEL_R4 = 3'd2;
    localparam logic [2:0] SEL_R5 = 3'd3;
    localparam logic [2:0] SEL_GA = 3'd4;
    localparam logic [2:0] SEL_GB = 3'd5;

    typedef logic [7:0] subst_tbl_t [6][16];
    typedef logic [7:0] group_map_t [16];

    localparam subst_tbl_t UNPACK_TBL = '{
        '{8'h5a,8'h1a,8'h58,8'h18,8'h52,8'h12,8'h50,8'h10,
          8'h4a,8'h0a,8'h48,8'h08,8'h42,8'h02,8'h40,8'h00},
        '{8'h18,8'h10,8'h08,8'h00,8'h58,8'h50,8'h48,8'h40,
          8'h1a,8'h12,8'h0a,8'h02,8'h5a,8'h52,8'h4a,8'h42},
        '{8'h58,8'h48,8'h5a,8'h4a,8'h50,8'h40,8'h52,8'h42,
          8'h18,8'h08,8'h1a,8'h0a,8'h10,8'h00,8'h12,8'h02},
        '{8'h1a,8'h5a,8'h0a,8'h4a,8'h12,8'h52,8'h02,8'h42,
          8'h18,8'h58,8'h08,8'h48,8'h10,8'h50,8'h00,8'h40},
        '{8'h58,8'h50,8'h18,8'h10,8'h5a,8'h52,8'h1a,8'h12,
          8'h48,8'h40,8'h08,8'h00,8'h4a,8'h42,8'h0a,8'h02},
        '{8'h52,8'h42,8'h50,8'h40,8'h5a,8'h4a,8'h58,8'h48,
          8'h12,8'h02,8'h10,8'h00,8'h1a,8'h0a,8'h18,8'h08}
    };

    localparam subst_tbl_t PACK_TBL = '{
        '{8'h5a,8'h52,8'h4a,8'h42,8'h1a,8'h12,8'h0a,8'h02,
          8'h58,8'h50,8'h48,8'h40,8'h18,8'h10,8'h08,8'h00},
        '{8'h0a,8'h4a,8'h08,8'h48,8'h02,8'h42,8'h00,8'h40,
          8'h1a,8'h5a,8'h18,8'h58,8'h12,8'h52,8'h10,8'h50},
        '{8'h52,8'h5a,8'h42,8'h4a,8'h50,8'h58,8'h40,8'h48,
          8'h12,8'h1a,8'h02,8'h0a,8'h10,8'h18,8'h00,8'h08},
        '{8'h58,8'h18,8'h48,8'h08,8'h50,8'h10,8'h40,8'h00,
          8'h5a,8'h1a,8'h4a,8'h0a,8'h52,8'h12,8'h42,8'h02},
        '{8'h4a,8'h5a,8'h48,8'h58,8'h0a,8'h1a,8'h08,8'h18,
          8'h42,8'h52,8'h40,8'h50,8'h02,8'h12,8'h00,8'h10},
        '{8'h4a,8'h42,8'h5a,8'h52,8'h48,8'h40,8'h58,8'h50,
          8'h0a,8'h02,8'h1a,8'h12,8'h08,8'h00,8'h18,8'h10}
    };

    localparam group_map_t GROUP_MAP = '{
        8'h5a, 8'h5a, 8'haa, 8'haa, 8'h55, 8'h55, 8'ha5, 8'ha5,
        8'h5a, 8'h5a, 8'h55, 8'h55, 8'h5a, 8'h5a, 8'haa, 8'haa
    };

    function automatic logic [2:0] pick_table(input logic [ADDR_W-1:0] addr);
        logic [3:0] byte_ix;
        logic [2:0] sel;
        byte_ix = {addr[8], addr[5:3]};
        case (addr[14:12])
            3'd0: sel = SEL_R0;
            3'd1: sel = SEL_R1;
            3'd4: sel = SEL_R4;
            3'd5: sel = SEL_R5;
            default: sel = GROUP_MAP[byte_ix][~addr[2:0]] ? SEL_GB : SEL_GA;
        endcase
        return sel;
    endfunction

    function automatic logic [DATA_W-1:0] transform(
        input logic              dir,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] din
    );
        logic [3:0] idx;
        logic [2:0] sel;
        logic [7:0] sub;
        idx = {din[6], din[4], din[3], din[1]};
        sel = pick_table(addr);
        sub = (dir == DIR_PACK) ? PACK_TBL[sel][idx] : UNPACK_TBL[sel][idx];
        return (din & KEEP_MASK) | (sub & SUBST_MASK);
    endfunction

endpackage

FILE: hw/rtl/rbd_if.sv
// Valid/ready channel interfaces for the ROM byte descrambler.
interface rbd_req_if;
    logic                       valid;
    logic                       ready;
    logic [rbd_pkg::ADDR_W-1:0] address;
    logic [rbd_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output address, output data_in, input ready);
    modport sink   (input valid, input address, input data_in, output ready);
endinterface

interface rbd_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [rbd_pkg::DATA_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

FILE: hw/rtl/rom_byte_descrambler.sv
// Top level of the ROM byte descrambler: APB mode register and two-stage datapath.
//
// Usage: items arrive on the raw channel (address, data_in) and leave on the
// result channel (data_out), both valid/ready. An item is taken at a clock edge
// with valid and ready high. Each item yields exactly one result item.
// An accepted item passes the input register, then the table lookup into the
// result register. Throughput: one item per cycle unless the receiver stalls.
// Each lookup reads one 16-entry table, chosen by address bits 14..12 and, for
// values 2, 3, 6 and 7 there, by address bits 8 and 5..0.
// The APB port holds one register, direction at byte address 0 (0 = unpack,
// 1 = pack); write it only while no items are in flight.
// Reset (rst_n low, asynchronous) empties both stages and sets direction to
// unpack. When the receiver stalls, the result register holds its item; the
// input stage keeps accepting until it also holds an item, then raw.ready drops.
module rom_byte_descrambler (
    input  logic                                clk,
    input  logic                                rst_n,
    rbd_req_if.sink                             raw,
    rbd_rsp_if.source                           result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rbd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rbd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic                       direction_reg;
    logic                       direction_next;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [rbd_pkg::ADDR_W-1:0] s1_address_reg;
    logic [rbd_pkg::DATA_W-1:0] s1_data_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [rbd_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_advance;
    logic                       s1_advance;
    logic                       reg_write;

    // config port
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && (paddr == rbd_pkg::REG_DIRECTION);
    assign direction_next = reg_write ? pwdata[0] : direction_reg;

    always_comb
    begin
        prdata = '0;
        if (paddr == rbd_pkg::REG_DIRECTION)
        begin
            prdata[0] = direction_reg;
        end
    end

    // handshake
    assign out_advance    = !out_valid_reg || result.ready;
    assign s1_advance     = !s1_valid_reg || out_advance;
    assign raw.ready      = s1_advance;
    assign s1_valid_next  = s1_advance ? raw.valid : s1_valid_reg;
    assign out_valid_next = out_advance ? s1_valid_reg : out_valid_reg;

    assign result.valid    = out_valid_reg;
    assign result.data_out = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= rbd_pkg::DIR_UNPACK;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && raw.valid)
        begin
            s1_address_reg <= raw.address;
            s1_data_reg    <= raw.data_in;
        end
        if (out_advance && s1_valid_reg)
        begin
            out_data_reg <= rbd_pkg::transform(direction_reg, s1_address_reg, s1_data_reg);
        end
    end

endmodule
